// File: design/feather_seam_blend_defines.svh
// Assertion macros used by feather_seam_blend.sv.
`ifndef FEATHER_SEAM_BLEND_DEFINES_SVH
`define FEATHER_SEAM_BLEND_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FSB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("feather seam blend: assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define FSB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("feather seam blend: assertion failed");

`endif

// File: design/fsb_pkg.sv
package fsb_pkg;

    // Field widths.
    localparam int COL_W     = 12;
    localparam int WIDTH_W   = 13;
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 3;
    localparam int QUOT_W    = 16;
    localparam int WEIGHT_W  = QUOT_W + 1;
    localparam int PROD_W    = CH_W + WEIGHT_W;
    localparam int CFG_IDX_W = 2;

    // Largest image width, also the reset value of the width register.
    localparam int MAX_WIDTH = 4096;

    // Q1.16 weight of one.
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << QUOT_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_START = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = CFG_IDX_W'(1);

    // How the base weight of a pixel is formed.
    localparam logic [1:0] WMODE_DIV  = 2'd0;
    localparam logic [1:0] WMODE_ONE  = 2'd1;
    localparam logic [1:0] WMODE_ZERO = 2'd2;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [CH_W-1:0]  base_ch0;
        logic [CH_W-1:0]  base_ch1;
        logic [CH_W-1:0]  base_ch2;
        logic [CH_W-1:0]  warped_ch0;
        logic [CH_W-1:0]  warped_ch1;
        logic [CH_W-1:0]  warped_ch2;
    } t_fsb_in;

    typedef struct packed {
        logic [CH_W-1:0] out_ch0;
        logic [CH_W-1:0] out_ch1;
        logic [CH_W-1:0] out_ch2;
    } t_fsb_out;

    // Pixel pair as it travels through the divider stages.
    typedef struct packed {
        logic [1:0]                   mode;
        logic [NUM_CH-1:0][CH_W-1:0]  base;
        logic [NUM_CH-1:0][CH_W-1:0]  warped;
    } t_fsb_item;

endpackage

// File: design/fsb_div_pipe.sv
module fsb_div_pipe (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [fsb_pkg::WIDTH_W-1:0] i_span,
    input  logic                        i_valid,
    input  fsb_pkg::t_fsb_item          i_item,
    input  logic [fsb_pkg::COL_W-1:0]   i_rem,
    output logic                        o_valid,
    output fsb_pkg::t_fsb_item          o_item,
    output logic [fsb_pkg::QUOT_W-1:0]  o_quot
);
    import fsb_pkg::*;

    // One quotient bit per stage: restoring division of (rem << 16) by the span.
    logic      r_valid [QUOT_W];
    t_fsb_item r_item  [QUOT_W];
    logic [COL_W-1:0]  r_rem  [QUOT_W];
    logic [QUOT_W-1:0] r_quot [QUOT_W];

    genvar k;
    generate
        for (k = 0; k < QUOT_W; k++) begin : g_stage
            logic              prev_valid;
            t_fsb_item         prev_item;
            logic [COL_W-1:0]  prev_rem;
            logic [QUOT_W-1:0] prev_quot;
            logic [WIDTH_W-1:0] rem2;
            logic [WIDTH_W-1:0] diff;
            logic               ge;

            if (k == 0) begin : g_first
                assign prev_valid = i_valid;
                assign prev_item  = i_item;
                assign prev_rem   = i_rem;
                assign prev_quot  = '0;
            end else begin : g_next
                assign prev_valid = r_valid[k-1];
                assign prev_item  = r_item[k-1];
                assign prev_rem   = r_rem[k-1];
                assign prev_quot  = r_quot[k-1];
            end

            // Shift the partial remainder and try to take off the span.
            assign rem2 = {prev_rem, 1'b0};
            assign ge   = (rem2 >= i_span);
            assign diff = rem2 - i_span;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else if (i_en) begin
                    r_valid[k] <= prev_valid;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_item[k] <= prev_item;
                    r_rem[k]  <= ge ? diff[COL_W-1:0] : rem2[COL_W-1:0];
                    r_quot[k] <= {prev_quot[QUOT_W-2:0], ge};
                end
            end
        end
    endgenerate

    assign o_valid = r_valid[QUOT_W-1];
    assign o_item  = r_item[QUOT_W-1];
    assign o_quot  = r_quot[QUOT_W-1];

endmodule

// File: design/feather_seam_blend.sv
// Channel  | Direction | Handshake                     | Word
// ---------+-----------+-------------------------------+--------------------------
// input    | in        | i_in_valid / o_in_ready       | i_in_word (t_fsb_in)
// output   | out       | o_out_valid / i_out_ready     | o_out_word (t_fsb_out)
// config   | in        | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// One word is accepted per cycle while the output is not stalled; each result passes
// through one entry stage, sixteen divider stages (one weight bit each), a multiply
// stage and the output register.
// Reset is synchronous and active low; it empties the pipeline and loads the registers
// with overlap start 0 and image width 4096.
// A stall on the output holds every stage; config writes are always taken.
`include "feather_seam_blend_defines.svh"

module feather_seam_blend (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  fsb_pkg::t_fsb_in              i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output fsb_pkg::t_fsb_out             o_out_word,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fsb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fsb_pkg::WIDTH_W-1:0]   i_cfg_data
);
    import fsb_pkg::*;

    logic [COL_W-1:0]   r_overlap_start;
    logic [WIDTH_W-1:0] r_image_width;
    logic               en;
    logic [WIDTH_W-1:0] span;

    // Configuration registers; the width saturates at the maximum.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overlap_start <= '0;
            r_image_width   <= WIDTH_W'(MAX_WIDTH);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_OVERLAP_START) begin
                r_overlap_start <= i_cfg_data[COL_W-1:0];
            end else if (i_cfg_index == CFG_IMAGE_WIDTH) begin
                r_image_width <= (i_cfg_data > WIDTH_W'(MAX_WIDTH)) ?
                                 WIDTH_W'(MAX_WIDTH) : i_cfg_data;
            end
        end
    end

    // The whole pipeline moves whenever the output register can take a word.
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;
    assign span       = r_image_width - {1'b0, r_overlap_start};

    // Entry stage: classify the column and form the dividend of the weight.
    logic               r_s0_valid;
    t_fsb_item          r_s0_item;
    logic [COL_W-1:0]   r_s0_rem;
    logic [WIDTH_W-1:0] n_rem;
    logic [1:0]         n_mode;
    logic               black;

    assign black = (i_in_word.warped_ch0 == '0) && (i_in_word.warped_ch1 == '0) &&
                   (i_in_word.warped_ch2 == '0);
    assign n_rem = r_image_width - {1'b0, i_in_word.column};

    always_comb begin
        priority if ({1'b0, i_in_word.column} >= r_image_width) begin
            n_mode = WMODE_ZERO;
        end else if (i_in_word.column <= r_overlap_start || black) begin
            n_mode = WMODE_ONE;
        end else begin
            n_mode = WMODE_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_item.mode   <= n_mode;
            r_s0_item.base   <= {i_in_word.base_ch2, i_in_word.base_ch1,
                                 i_in_word.base_ch0};
            r_s0_item.warped <= {i_in_word.warped_ch2, i_in_word.warped_ch1,
                                 i_in_word.warped_ch0};
            r_s0_rem         <= n_rem[COL_W-1:0];
        end
    end

    // Weight division, one bit per stage.
    logic              div_valid;
    t_fsb_item         div_item;
    logic [QUOT_W-1:0] div_quot;

    fsb_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_span  (span),
        .i_valid (r_s0_valid),
        .i_item  (r_s0_item),
        .i_rem   (r_s0_rem),
        .o_valid (div_valid),
        .o_item  (div_item),
        .o_quot  (div_quot)
    );

    // Multiply stage: pick the weight and form both weighted terms per channel.
    logic [WEIGHT_W-1:0] weight;
    logic [WEIGHT_W-1:0] weight_inv;
    logic                r_m_valid;
    logic [1:0]          r_m_mode;
    logic [NUM_CH-1:0][CH_W-1:0] r_m_base;
    logic [PROD_W-1:0]   r_m_bw [NUM_CH];
    logic [PROD_W-1:0]   r_m_tw [NUM_CH];

    always_comb begin
        unique case (div_item.mode)
            WMODE_ONE:  weight = WEIGHT_ONE;
            WMODE_ZERO: weight = '0;
            WMODE_DIV:  weight = {1'b0, div_quot};
            default:    weight = '0;
        endcase
    end

    assign weight_inv = WEIGHT_ONE - weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_mode <= div_item.mode;
            r_m_base <= div_item.base;
            for (int c = 0; c < NUM_CH; c++) begin
                r_m_bw[c] <= {{WEIGHT_W{1'b0}}, div_item.base[c]} * {{CH_W{1'b0}}, weight};
                r_m_tw[c] <= {{WEIGHT_W{1'b0}}, div_item.warped[c]} *
                             {{CH_W{1'b0}}, weight_inv};
            end
        end
    end

    // Output stage: add the terms and drop the fraction.
    logic [PROD_W-1:0] sum [NUM_CH];
    logic              r_out_valid;
    t_fsb_out          r_out_word;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            sum[c] = r_m_bw[c] + r_m_tw[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_word.out_ch0 <= sum[0][QUOT_W+CH_W-1:QUOT_W];
            r_out_word.out_ch1 <= sum[1][QUOT_W+CH_W-1:QUOT_W];
            r_out_word.out_ch2 <= sum[2][QUOT_W+CH_W-1:QUOT_W];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // The stored width never exceeds the maximum.
    `FSB_ASSERT_NEXT(a_width_max, i_clk, i_rst_n, i_cfg_valid && i_cfg_index == CFG_IMAGE_WIDTH, r_image_width <= WIDTH_W'(MAX_WIDTH))
    // A column at or past the width gets weight zero for the base pixel.
    `FSB_ASSERT_NEXT(a_past_width, i_clk, i_rst_n, i_in_valid && o_in_ready && {1'b0, i_in_word.column} >= r_image_width, r_s0_item.mode == WMODE_ZERO)
    // A pixel with base weight one leaves as its base pixel.
    `FSB_ASSERT_NEXT(a_pass_base, i_clk, i_rst_n, en && r_m_valid && r_m_mode == WMODE_ONE, o_out_word.out_ch0 == $past(r_m_base[0]) && o_out_word.out_ch2 == $past(r_m_base[2]))

endmodule
